// ===== rtl/swsc_pkg.sv =====
`default_nettype none
package swsc_pkg;

    localparam int CHANNELS    = 4;
    localparam int NUM_BINS    = 256;
    localparam int MAX_HISTORY = 16;

    localparam int ACC_W = 54;
    localparam int Q_W   = ACC_W + 1;
    localparam int DSR_W = 22;
    localparam int SUM_W = 57;

    typedef enum logic [0:0] {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_DIAGONAL_LOAD = 1'b1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_META,
        S_COMMIT,
        S_WRD,
        S_WADD,
        S_ENTRY,
        S_RD,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_ACC,
        S_W0,
        S_W1,
        S_W2,
        S_DRS,
        S_DRW,
        S_DIS,
        S_DIW,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic        [15:0] w;
    } t_sample;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] res;
        if (v > SUM_W'(64'sd2147483647)) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -SUM_W'(64'sd2147483648)) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/swsc_div.sv =====
`default_nettype none
module swsc_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [swsc_pkg::ACC_W-1:0] i_num,
    input  wire logic        [swsc_pkg::DSR_W-1:0] i_den,
    output logic                                   o_done,
    output logic signed      [swsc_pkg::Q_W-1:0]   o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [5:0]                    r_cnt;
    logic [swsc_pkg::ACC_W-1:0]    r_mag;
    logic [swsc_pkg::DSR_W-1:0]    r_rem;
    logic                          r_neg;
    logic [swsc_pkg::DSR_W:0]      n_rem_sh;
    logic [swsc_pkg::DSR_W:0]      n_diff;
    logic                          n_ge;

    assign n_rem_sh = {r_rem, r_mag[swsc_pkg::ACC_W-1]};
    assign n_ge     = n_rem_sh >= {1'b0, i_den};
    assign n_diff   = n_rem_sh - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(swsc_pkg::ACC_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[swsc_pkg::ACC_W-1];
            r_mag <= i_num[swsc_pkg::ACC_W-1] ? -i_num : i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[swsc_pkg::DSR_W-1:0] : n_rem_sh[swsc_pkg::DSR_W-1:0];
            r_mag <= {r_mag[swsc_pkg::ACC_W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});

endmodule
`default_nettype wire

// ===== rtl/sliding_window_spatial_covariance.sv =====
`default_nettype none
// Channel  | Handshake                    | Payload
// input    | start, busy                  | i_func i_bin i_chan i_sample_re/im i_weight i_last_chan
// config   | i_cfg_valid, o_cfg_ready     | i_cfg_index, i_cfg_data
// result   | o_valid (one-cycle strobe)   | o_kind o_out_bin o_row o_col o_cov_re/im o_no_weight o_last
//
// A sample without last_chan is stored without raising busy. A last_chan sample keeps busy high
// while the snapshot is committed and the matrix is computed over the N stored snapshots, its
// length set by the single multiplier stepping over the window per entry and the bit-serial divider;
// a zero weight sum skips both.
// After reset a clearing pass over the count/head memory holds busy high.
// Results are strobed one per entry and cannot be stalled.
module sliding_window_spatial_covariance (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_func,
    input  wire logic [7:0]         i_bin,
    input  wire logic [1:0]         i_chan,
    input  wire logic signed [15:0] i_sample_re,
    input  wire logic signed [15:0] i_sample_im,
    input  wire logic [15:0]        i_weight,
    input  wire logic               i_last_chan,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    output logic                    o_valid,
    output logic                    o_kind,
    output logic [7:0]              o_out_bin,
    output logic [1:0]              o_row,
    output logic [1:0]              o_col,
    output logic signed [31:0]      o_cov_re,
    output logic signed [31:0]      o_cov_im,
    output logic                    o_no_weight,
    output logic                    o_last
);

    swsc_pkg::t_state r_state, n_state;

    logic [4:0]                          r_wl;
    logic signed [31:0]                  r_load;
    swsc_pkg::t_sample                   r_snap [swsc_pkg::CHANNELS];
    swsc_pkg::t_sample                   r_hist [2*swsc_pkg::NUM_BINS*swsc_pkg::MAX_HISTORY*
                                                 swsc_pkg::CHANNELS];
    logic [8:0]                          r_meta [2*swsc_pkg::NUM_BINS];
    swsc_pkg::t_sample                   r_rda, r_rdb;
    logic [8:0]                          r_meta_q;
    logic [8:0]                          r_clr;
    logic                                r_func;
    logic [7:0]                          r_bin;
    logic [3:0]                          r_head, r_slot;
    logic [4:0]                          r_cnt, r_n;
    logic [1:0]                          r_c;
    logic [5:0]                          r_k;
    logic [swsc_pkg::DSR_W-1:0]          r_wsum;
    logic [3:0]                          r_e;
    logic signed [49:0]                  r_prod;
    logic signed [32:0]                  r_pr, r_pi;
    logic signed [swsc_pkg::ACC_W-1:0]   r_acc_re, r_acc_im;
    logic signed [swsc_pkg::Q_W-1:0]     r_qre, r_qim;

    logic                                n_accept;
    logic [14:0]                         n_addr_a, n_addr_b;
    logic                                n_hist_we;
    logic signed [32:0]                  n_mul_a;
    logic signed [16:0]                  n_mul_b;
    logic signed [49:0]                  n_prod;
    logic                                n_div_start;
    logic signed [swsc_pkg::ACC_W-1:0]   n_div_num;
    logic                                div_done;
    logic signed [swsc_pkg::Q_W-1:0]     div_quot;
    logic [4:0]                          n_wl, n_drop, n_mcnt;
    logic [3:0]                          n_mhead;
    logic [1:0]                          n_i, n_j, n_a, n_b;
    logic                                n_diag, n_last_n, n_last_k;
    logic signed [swsc_pkg::SUM_W-1:0]   n_re_sum, n_im_val;

    assign n_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign n_i         = r_e[3:2];
    assign n_j         = r_e[1:0];
    assign n_a         = (n_i <= n_j) ? n_i : n_j;
    assign n_b         = (n_i <= n_j) ? n_j : n_i;
    assign n_diag      = n_i == n_j;
    assign n_last_n    = (r_n + 5'd1) == r_cnt;
    assign n_last_k    = ({1'b0, r_k} + 7'd1) == {r_cnt, 2'b00};
    assign n_prod      = n_mul_a * n_mul_b;

    always_comb begin
        n_wl = r_wl;
        if (r_wl == 5'd0) begin
            n_wl = 5'd1;
        end else if (r_wl > 5'(swsc_pkg::MAX_HISTORY)) begin
            n_wl = 5'(swsc_pkg::MAX_HISTORY);
        end
        n_mcnt  = r_meta_q[8:4];
        n_mhead = r_meta_q[3:0];
        n_drop  = n_mcnt - n_wl + 5'd1;
        if (n_mcnt >= n_wl) begin
            n_mhead = r_meta_q[3:0] + n_drop[3:0];
            n_mcnt  = n_wl - 5'd1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swsc_pkg::S_CLEAR:  if (r_clr == 9'h1FF) n_state = swsc_pkg::S_IDLE;
            swsc_pkg::S_IDLE:   if (n_accept && i_last_chan) n_state = swsc_pkg::S_META;
            swsc_pkg::S_META:   n_state = swsc_pkg::S_COMMIT;
            swsc_pkg::S_COMMIT: if (r_c == 2'd3) n_state = swsc_pkg::S_WRD;
            swsc_pkg::S_WRD:    n_state = swsc_pkg::S_WADD;
            swsc_pkg::S_WADD:   n_state = n_last_k ? swsc_pkg::S_ENTRY : swsc_pkg::S_WRD;
            swsc_pkg::S_ENTRY:  n_state = (r_wsum == '0) ? swsc_pkg::S_EMIT : swsc_pkg::S_RD;
            swsc_pkg::S_RD:     n_state = swsc_pkg::S_P0;
            swsc_pkg::S_P0:     n_state = swsc_pkg::S_P1;
            swsc_pkg::S_P1:     n_state = swsc_pkg::S_P2;
            swsc_pkg::S_P2:     n_state = swsc_pkg::S_P3;
            swsc_pkg::S_P3:     n_state = swsc_pkg::S_P4;
            swsc_pkg::S_P4:     n_state = r_func ? swsc_pkg::S_W0 : swsc_pkg::S_ACC;
            swsc_pkg::S_ACC:    n_state = n_last_n ? swsc_pkg::S_DRS : swsc_pkg::S_RD;
            swsc_pkg::S_W0:     n_state = swsc_pkg::S_W1;
            swsc_pkg::S_W1:     n_state = swsc_pkg::S_W2;
            swsc_pkg::S_W2:     n_state = n_last_n ? swsc_pkg::S_DRS : swsc_pkg::S_RD;
            swsc_pkg::S_DRS:    n_state = swsc_pkg::S_DRW;
            swsc_pkg::S_DRW:    if (div_done) n_state = n_diag ? swsc_pkg::S_EMIT : swsc_pkg::S_DIS;
            swsc_pkg::S_DIS:    n_state = swsc_pkg::S_DIW;
            swsc_pkg::S_DIW:    if (div_done) n_state = swsc_pkg::S_EMIT;
            swsc_pkg::S_EMIT:   n_state = (r_e == 4'hF) ? swsc_pkg::S_IDLE : swsc_pkg::S_ENTRY;
            default:            n_state = swsc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        busy        = r_state != swsc_pkg::S_IDLE;
        n_hist_we   = r_state == swsc_pkg::S_COMMIT;
        n_div_start = (r_state == swsc_pkg::S_DRS) || (r_state == swsc_pkg::S_DIS);
        n_div_num   = (r_state == swsc_pkg::S_DIS) ? r_acc_im : r_acc_re;
        if (!r_func) begin
            n_div_num = n_div_num <<< 16;
        end
        if (r_state == swsc_pkg::S_COMMIT) begin
            n_addr_a = {r_func, r_bin, r_slot, r_c};
        end else if ((r_state == swsc_pkg::S_WRD) || (r_state == swsc_pkg::S_WADD)) begin
            n_addr_a = {r_func, r_bin, r_head + r_k[5:2], r_k[1:0]};
        end else begin
            n_addr_a = {r_func, r_bin, r_head + r_n[3:0], n_a};
        end
        n_addr_b = {r_func, r_bin, r_head + r_n[3:0], n_b};
        n_mul_a  = 33'(r_rda.re);
        n_mul_b  = 17'(r_rdb.re);
        unique case (r_state)
            swsc_pkg::S_P1: begin
                n_mul_a = 33'(r_rda.im);
                n_mul_b = 17'(r_rdb.im);
            end
            swsc_pkg::S_P2: begin
                n_mul_a = 33'(r_rda.im);
                n_mul_b = 17'(r_rdb.re);
            end
            swsc_pkg::S_P3: begin
                n_mul_a = 33'(r_rda.re);
                n_mul_b = 17'(r_rdb.im);
            end
            swsc_pkg::S_W0: begin
                n_mul_a = r_pr;
                n_mul_b = $signed({1'b0, r_rdb.w});
            end
            swsc_pkg::S_W1: begin
                n_mul_a = r_pi;
                n_mul_b = $signed({1'b0, r_rdb.w});
            end
            default: begin
                n_mul_a = 33'(r_rda.re);
                n_mul_b = 17'(r_rdb.re);
            end
        endcase
    end

    always_comb begin
        n_re_sum = swsc_pkg::SUM_W'(r_qre);
        if (n_diag && r_func) begin
            n_re_sum = n_re_sum + swsc_pkg::SUM_W'(r_load);
        end
        if (n_diag) begin
            n_im_val = '0;
        end else if (n_i > n_j) begin
            n_im_val = -swsc_pkg::SUM_W'(r_qim);
        end else begin
            n_im_val = swsc_pkg::SUM_W'(r_qim);
        end
    end

    swsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_num   (n_div_num),
        .i_den   (r_wsum),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (n_hist_we) begin
            r_hist[n_addr_a] <= r_snap[r_c];
        end
        r_rda <= r_hist[n_addr_a];
        r_rdb <= r_hist[n_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == swsc_pkg::S_CLEAR) begin
            r_meta[r_clr] <= '0;
        end else if (r_state == swsc_pkg::S_META) begin
            r_meta[{r_func, r_bin}] <= {n_mcnt + 5'd1, n_mhead};
        end
        r_meta_q <= r_meta[{i_func, i_bin}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swsc_pkg::S_CLEAR;
            r_clr   <= '0;
            r_wl    <= 5'd16;
            r_load  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= r_state == swsc_pkg::S_EMIT;
            if (r_state == swsc_pkg::S_CLEAR) begin
                r_clr <= r_clr + 9'd1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (swsc_pkg::t_cfg_idx'(i_cfg_index))
                    swsc_pkg::CFG_WINDOW_LENGTH: r_wl   <= i_cfg_data[4:0];
                    swsc_pkg::CFG_DIAGONAL_LOAD: r_load <= i_cfg_data;
                    default:                     r_wl   <= r_wl;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (n_accept) begin
            r_snap[i_chan] <= '{re: i_sample_re, im: i_sample_im, w: i_weight};
            r_func         <= i_func;
            r_bin          <= i_bin;
        end
        unique case (r_state)
            swsc_pkg::S_META: begin
                r_head <= n_mhead;
                r_cnt  <= n_mcnt + 5'd1;
                r_slot <= n_mhead + n_mcnt[3:0];
                r_c    <= '0;
            end
            swsc_pkg::S_COMMIT: begin
                r_c    <= r_c + 2'd1;
                r_k    <= '0;
                r_wsum <= '0;
                r_e    <= '0;
            end
            swsc_pkg::S_WADD: begin
                r_wsum <= r_wsum + swsc_pkg::DSR_W'(r_rda.w);
                r_k    <= r_k + 6'd1;
            end
            swsc_pkg::S_ENTRY: begin
                r_n      <= '0;
                r_acc_re <= '0;
                r_acc_im <= '0;
            end
            swsc_pkg::S_P1: r_pr <= 33'(r_prod);
            swsc_pkg::S_P2: r_pr <= r_pr + 33'(r_prod);
            swsc_pkg::S_P3: r_pi <= 33'(r_prod);
            swsc_pkg::S_P4: r_pi <= r_pi - 33'(r_prod);
            swsc_pkg::S_ACC: begin
                r_acc_re <= r_acc_re + swsc_pkg::ACC_W'(r_pr);
                r_acc_im <= r_acc_im + swsc_pkg::ACC_W'(r_pi);
                r_n      <= r_n + 5'd1;
            end
            swsc_pkg::S_W1: r_acc_re <= r_acc_re + swsc_pkg::ACC_W'(r_prod);
            swsc_pkg::S_W2: begin
                r_acc_im <= r_acc_im + swsc_pkg::ACC_W'(r_prod);
                r_n      <= r_n + 5'd1;
            end
            swsc_pkg::S_DRW: if (div_done) r_qre <= div_quot;
            swsc_pkg::S_DIW: if (div_done) r_qim <= div_quot;
            swsc_pkg::S_EMIT: begin
                o_kind      <= r_func;
                o_out_bin   <= r_bin;
                o_row       <= n_i;
                o_col       <= n_j;
                o_last      <= r_e == 4'hF;
                o_no_weight <= r_wsum == '0;
                o_cov_re    <= (r_wsum == '0) ? '0 : swsc_pkg::sat32(n_re_sum);
                o_cov_im    <= (r_wsum == '0) ? '0 : swsc_pkg::sat32(n_im_val);
                r_e         <= r_e + 4'd1;
            end
            default: r_k <= r_k;
        endcase
    end

    a_zero_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_weight |-> o_cov_re == '0 && o_cov_im == '0)
        else $error("zero weight entry not zero");

    a_diag_im: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_row == o_col) |-> o_cov_im == '0)
        else $error("diagonal imaginary part not zero");

    a_commit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_last_chan |=> busy)
        else $error("snapshot commit did not start");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_row == 2'd3 && o_col == 2'd3 && !busy)
        else $error("matrix end misplaced");

endmodule
`default_nettype wire

// ===== verif/sliding_window_spatial_covariance_tb.sv =====
module sliding_window_spatial_covariance_tb;

    localparam int  CLK_HALF   = 4;
    localparam int  DRAIN_WAIT = 6000;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct {
        bit                kind;
        bit [7:0]          bin;
        bit [1:0]          row;
        bit [1:0]          col;
        bit signed [31:0]  re;
        bit signed [31:0]  im;
        bit                no_weight;
        bit                last;
    } cov_entry_t;

    typedef struct {
        shortint  re;
        shortint  im;
        bit [15:0] w;
    } chan_sample_t;

    class cov_scoreboard;
        bit [4:0]      window_len;
        longint        diag_load;
        chan_sample_t  snap [swsc_pkg::CHANNELS];
        chan_sample_t  hist [2*swsc_pkg::NUM_BINS][swsc_pkg::MAX_HISTORY][swsc_pkg::CHANNELS];
        int unsigned   hist_cnt [2*swsc_pkg::NUM_BINS];
        int unsigned   hist_head [2*swsc_pkg::NUM_BINS];
        cov_entry_t    pending_entries [$];
        int            errors;

        function new();
            window_len = 16;
            diag_load  = 0;
            errors     = 0;
            foreach (hist_cnt[k]) begin
                hist_cnt[k]  = 0;
                hist_head[k] = 0;
            end
        endfunction

        function void write_reg(swsc_pkg::t_cfg_idx idx, bit [31:0] d);
            if (idx == swsc_pkg::CFG_WINDOW_LENGTH) begin
                window_len = d[4:0];
            end else begin
                diag_load = longint'(signed'(d));
            end
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void note_input(bit f, bit [7:0] b, bit [1:0] c, shortint sre, shortint sim,
                                 bit [15:0] w, bit lc);
            int unsigned wl, q, cnt, head, slot, drop;
            longint acc_re [swsc_pkg::CHANNELS][swsc_pkg::CHANNELS];
            longint acc_im [swsc_pkg::CHANNELS][swsc_pkg::CHANNELS];
            longint wsum, pr, pi, nr, ni, re, im;
            chan_sample_t si, sj;
            cov_entry_t e;
            int a, bb;
            snap[c].re = sre;
            snap[c].im = sim;
            snap[c].w  = w;
            if (!lc) return;
            wl = window_len;
            if (wl == 0) wl = 1;
            if (wl > swsc_pkg::MAX_HISTORY) wl = swsc_pkg::MAX_HISTORY;
            q    = f * swsc_pkg::NUM_BINS + b;
            cnt  = hist_cnt[q];
            head = hist_head[q];
            if (cnt >= wl) begin
                drop = cnt - wl + 1;
                head = (head + drop) % swsc_pkg::MAX_HISTORY;
                cnt -= drop;
            end
            slot = (head + cnt) % swsc_pkg::MAX_HISTORY;
            for (int i = 0; i < swsc_pkg::CHANNELS; i++) hist[q][slot][i] = snap[i];
            cnt++;
            hist_cnt[q]  = cnt;
            hist_head[q] = head;
            wsum = 0;
            for (int i = 0; i < swsc_pkg::CHANNELS; i++)
                for (int j = 0; j < swsc_pkg::CHANNELS; j++) begin
                    acc_re[i][j] = 0;
                    acc_im[i][j] = 0;
                end
            for (int n = 0; n < cnt; n++) begin
                slot = (head + n) % swsc_pkg::MAX_HISTORY;
                for (int i = 0; i < swsc_pkg::CHANNELS; i++) begin
                    si = hist[q][slot][i];
                    wsum += si.w;
                    for (int j = i; j < swsc_pkg::CHANNELS; j++) begin
                        sj = hist[q][slot][j];
                        pr = longint'(si.re) * sj.re + longint'(si.im) * sj.im;
                        pi = longint'(si.im) * sj.re - longint'(si.re) * sj.im;
                        if (f) begin
                            pr *= longint'(sj.w);
                            pi *= longint'(sj.w);
                        end
                        acc_re[i][j] += pr;
                        acc_im[i][j] += pi;
                    end
                end
            end
            for (int i = 0; i < swsc_pkg::CHANNELS; i++) begin
                for (int j = 0; j < swsc_pkg::CHANNELS; j++) begin
                    re = 0;
                    im = 0;
                    if (wsum != 0) begin
                        a  = (i <= j) ? i : j;
                        bb = (i <= j) ? j : i;
                        nr = acc_re[a][bb];
                        ni = acc_im[a][bb];
                        if (!f) begin
                            nr *= 65536;
                            ni *= 65536;
                        end
                        re = nr / wsum;
                        im = ni / wsum;
                        if (i > j) im = -im;
                        if (i == j) begin
                            im = 0;
                            if (f) re += diag_load;
                        end
                        re = clip32(re);
                        im = clip32(im);
                    end
                    e.kind      = f;
                    e.bin       = b;
                    e.row       = 2'(i);
                    e.col       = 2'(j);
                    e.re        = re[31:0];
                    e.im        = im[31:0];
                    e.no_weight = (wsum == 0);
                    e.last      = (i == swsc_pkg::CHANNELS-1 && j == swsc_pkg::CHANNELS-1);
                    pending_entries.push_back(e);
                end
            end
        endfunction

        function void check_result(cov_entry_t got);
            cov_entry_t exp_e;
            if (pending_entries.size() == 0) begin
                $error("unexpected result bin=%0d row=%0d col=%0d", got.bin, got.row, got.col);
                errors++;
                return;
            end
            exp_e = pending_entries.pop_front();
            if (got.kind != exp_e.kind) begin
                $error("kind: expected %0d actual %0d", exp_e.kind, got.kind);
                errors++;
            end
            if (got.bin != exp_e.bin) begin
                $error("out_bin: expected %0d actual %0d", exp_e.bin, got.bin);
                errors++;
            end
            if (got.row != exp_e.row) begin
                $error("row: expected %0d actual %0d", exp_e.row, got.row);
                errors++;
            end
            if (got.col != exp_e.col) begin
                $error("col: expected %0d actual %0d", exp_e.col, got.col);
                errors++;
            end
            if (got.re != exp_e.re) begin
                $error("cov_re: expected %0d actual %0d", exp_e.re, got.re);
                errors++;
            end
            if (got.im != exp_e.im) begin
                $error("cov_im: expected %0d actual %0d", exp_e.im, got.im);
                errors++;
            end
            if (got.no_weight != exp_e.no_weight) begin
                $error("no_weight: expected %0d actual %0d", exp_e.no_weight, got.no_weight);
                errors++;
            end
            if (got.last != exp_e.last) begin
                $error("last: expected %0d actual %0d", exp_e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_func;
    logic [7:0]         i_bin;
    logic [1:0]         i_chan;
    logic signed [15:0] i_sample_re;
    logic signed [15:0] i_sample_im;
    logic [15:0]        i_weight;
    logic               i_last_chan;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [0:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               o_valid;
    logic               o_kind;
    logic [7:0]         o_out_bin;
    logic [1:0]         o_row;
    logic [1:0]         o_col;
    logic signed [31:0] o_cov_re;
    logic signed [31:0] o_cov_im;
    logic               o_no_weight;
    logic               o_last;

    sliding_window_spatial_covariance u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_bin       (i_bin),
        .i_chan      (i_chan),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .i_weight    (i_weight),
        .i_last_chan (i_last_chan),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_out_bin   (o_out_bin),
        .o_row       (o_row),
        .o_col       (o_col),
        .o_cov_re    (o_cov_re),
        .o_cov_im    (o_cov_im),
        .o_no_weight (o_no_weight),
        .o_last      (o_last)
    );

    cov_scoreboard sb = new();
    int     idle_pct = 0;
    longint cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cov_entry_t got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n && start && !busy)
            sb.note_input(i_func, i_bin, i_chan, i_sample_re, i_sample_im, i_weight,
                          i_last_chan);
        if (i_rst_n && o_valid) begin
            got.kind      = o_kind;
            got.bin       = o_out_bin;
            got.row       = o_row;
            got.col       = o_col;
            got.re        = o_cov_re;
            got.im        = o_cov_im;
            got.no_weight = o_no_weight;
            got.last      = o_last;
            sb.check_result(got);
        end
    end

    task automatic send_sample(bit f, bit [7:0] b, bit [1:0] c, bit [15:0] re, bit [15:0] im,
                               bit [15:0] w, bit lc);
        start       <= 1'b1;
        i_func      <= f;
        i_bin       <= b;
        i_chan      <= c;
        i_sample_re <= re;
        i_sample_im <= im;
        i_weight    <= w;
        i_last_chan <= lc;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_snapshot(bit f, bit [7:0] b, bit [15:0] re, bit [15:0] im,
                                 bit [15:0] w);
        for (int c = 0; c < swsc_pkg::CHANNELS; c++)
            send_sample(f, b, 2'(c), re, im, w, c == swsc_pkg::CHANNELS-1);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending_entries.size() != 0 || busy);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(swsc_pkg::t_cfg_idx idx, bit [31:0] d);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic bit [15:0] rand_val();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit [15:0] rand_weight();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n_items);
        int sent;
        bit f;
        bit [7:0] b;
        sent = 0;
        while (sent < n_items) begin
            f = 1'($urandom);
            b = ($urandom_range(9) < 8) ? 8'($urandom_range(3)) : 8'($urandom);
            if ($urandom_range(9) < 8) begin
                for (int c = 0; c < swsc_pkg::CHANNELS; c++)
                    send_sample(f, b, 2'(c), rand_val(), rand_val(), rand_weight(),
                                c == swsc_pkg::CHANNELS-1);
                sent += swsc_pkg::CHANNELS;
            end else begin
                // partial snapshot or out-of-order channel, may or may not commit
                send_sample(f, b, 2'($urandom), rand_val(), rand_val(), rand_weight(),
                            1'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        start       = 1'b0;
        i_func      = 1'b0;
        i_bin       = '0;
        i_chan      = '0;
        i_sample_re = '0;
        i_sample_im = '0;
        i_weight    = '0;
        i_last_chan = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = swsc_pkg::CFG_WINDOW_LENGTH;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(swsc_pkg::CFG_WINDOW_LENGTH, 32'd16);
        write_reg(swsc_pkg::CFG_DIAGONAL_LOAD, 32'h7FFF_FFFF);
        // zero weight sum
        send_snapshot(1'b1, 8'd5, 16'h7FFF, 16'h8000, 16'h0000);
        // extremes, signal with tiny weights saturates
        send_snapshot(1'b0, 8'd255, 16'h8000, 16'h8000, 16'h0001);
        send_snapshot(1'b1, 8'd255, 16'h7FFF, 16'h8000, 16'hFFFF);
        // single-item commits reuse the held snapshot
        send_sample(1'b1, 8'd255, 2'd1, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1);
        send_sample(1'b1, 8'd255, 2'd2, 16'h1234, 16'h8000, 16'h0000, 1'b0);
        send_sample(1'b1, 8'd255, 2'd0, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1);
        // shrink the window below the stored history
        write_reg(swsc_pkg::CFG_WINDOW_LENGTH, 32'd1);
        write_reg(swsc_pkg::CFG_DIAGONAL_LOAD, 32'h8000_0000);
        send_sample(1'b1, 8'd255, 2'd3, 16'h0001, 16'hFFFF, 16'h0001, 1'b1);
        send_sample(1'b0, 8'd255, 2'd3, 16'hFFFF, 16'h0001, 16'h0002, 1'b1);

        write_reg(swsc_pkg::CFG_WINDOW_LENGTH, 32'd0);
        write_reg(swsc_pkg::CFG_DIAGONAL_LOAD, $urandom);
        idle_pct = 0;
        random_phase(40);

        write_reg(swsc_pkg::CFG_WINDOW_LENGTH, 32'd31);
        write_reg(swsc_pkg::CFG_DIAGONAL_LOAD, 32'h4000_0000);
        idle_pct = 69;
        random_phase(80);

        drain();
        write_reg(swsc_pkg::CFG_WINDOW_LENGTH, 32'd3);
        write_reg(swsc_pkg::CFG_DIAGONAL_LOAD, 32'hC000_0000);
        idle_pct = 0;
        random_phase(60);

        write_reg(swsc_pkg::CFG_WINDOW_LENGTH, 32'd16);
        write_reg(swsc_pkg::CFG_DIAGONAL_LOAD, $urandom);
        idle_pct = 29;
        random_phase(80);

        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending_entries.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_entries.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
